/* hdl/knxnet_ip_packet_classifier_core_assert.svh */
// Assertion macros for the KNXnet/IP classifier.
`ifndef KNXNET_IP_PACKET_CLASSIFIER_CORE_ASSERT_SVH
`define KNXNET_IP_PACKET_CLASSIFIER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define KNXC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("knxc assertion failed");
`define KNXC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("knxc assertion failed");
`else
`define KNXC_ASSERT_IMP(label, ante, cons)
`define KNXC_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* hdl/knxc_pkg.sv */
package knxc_pkg;

  localparam logic [7:0]  HDR_LEN   = 8'd6;
  localparam logic [15:0] MIN_LEN   = 16'd10;
  localparam logic [15:0] POS_MAX   = 16'hFFFF;
  localparam logic [7:0]  HDR_BYTE0 = 8'h06;
  localparam logic [7:0]  HDR_BYTE1 = 8'h10;

  // Service families.
  localparam logic [7:0] FAM_CORE    = 8'h02;
  localparam logic [7:0] FAM_DEVMGMT = 8'h03;
  localparam logic [7:0] FAM_TUNNEL  = 8'h04;
  localparam logic [7:0] FAM_ROUTING = 8'h05;
  localparam logic [7:0] FAM_REMLOG  = 8'h07;
  localparam logic [7:0] FAM_OBJSRV  = 8'h09;

  // Packet state as it stands after the byte under work has been taken in.
  typedef struct packed {
    logic [15:0]     len;
    logic            ovf;
    logic [5:0][7:0] hdr;
    logic [3:0][7:0] sec;
  } knxc_view_t;

  function automatic logic valid_service(input logic [7:0] family, input logic [7:0] code);
    logic ok;
    unique case (family)
      FAM_CORE:    ok = (code > 8'h00) && (code < 8'h0D);
      FAM_DEVMGMT: ok = (code >= 8'h10) && (code <= 8'h11);
      FAM_TUNNEL:  ok = (code >= 8'h20) && (code <= 8'h25);
      FAM_ROUTING: ok = (code >= 8'h30) && (code <= 8'h33);
      FAM_REMLOG:  ok = (code >= 8'h40) && (code <= 8'h43);
      FAM_OBJSRV:  ok = (code >= 8'h50) && (code <= 8'h55);
      default:     ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

/* hdl/knxc_track.sv */
module knxc_track (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               upd,
  input  logic [7:0]         data_byte,
  input  logic               last,
  output knxc_pkg::knxc_view_t view
);

  logic [15:0]     pos_r;
  logic            ovf_r;
  logic [5:0][7:0] hdr_r;
  logic [3:0][7:0] sec_r;

  logic [15:0] tl;
  logic        in_window;
  logic [1:0]  sec_idx;

  assign tl        = {hdr_r[4], hdr_r[5]};
  assign in_window = ({1'b0, pos_r} >= {1'b0, tl}) && ({1'b0, pos_r} < ({1'b0, tl} + 17'd4));
  assign sec_idx   = pos_r[1:0] - tl[1:0];

  always_comb begin
    view.len = pos_r;
    view.ovf = ovf_r;
    view.hdr = hdr_r;
    view.sec = sec_r;
    if (!ovf_r) begin
      if (pos_r < {8'd0, knxc_pkg::HDR_LEN}) begin
        view.hdr[pos_r[2:0]] = data_byte;
      end else if (in_window) begin
        view.sec[sec_idx] = data_byte;
      end
      if (pos_r == knxc_pkg::POS_MAX) begin
        view.ovf = 1'b1;
      end else begin
        view.len = pos_r + 16'd1;
      end
    end
  end

  // The state returns to its reset value after each verdict.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ovf_r <= 1'b0;
      hdr_r <= '0;
      sec_r <= '0;
    end else if (upd) begin
      if (last) begin
        pos_r <= '0;
        ovf_r <= 1'b0;
        hdr_r <= '0;
        sec_r <= '0;
      end else begin
        pos_r <= view.len;
        ovf_r <= view.ovf;
        hdr_r <= view.hdr;
        sec_r <= view.sec;
      end
    end
  end

endmodule

/* hdl/knxc_classify.sv */
module knxc_classify (
  input  knxc_pkg::knxc_view_t view,
  input  logic                 tcp,
  output logic                 verdict
);

  logic [16:0]     tl;
  logic [16:0]     len;
  logic            base_ok;
  logic            tcp_ok;
  logic [16:0]     off;
  logic [3:0][7:0] sec;

  assign tl  = {1'b0, view.hdr[4], view.hdr[5]};
  assign len = {1'b0, view.len};

  // A second header that starts inside the first six bytes is read from the header.
  always_comb begin
    off = '0;
    sec = '0;
    for (int k = 0; k < 4; k++) begin
      off = tl + 17'(k);
      if (off < {9'd0, knxc_pkg::HDR_LEN}) begin
        sec[k] = view.hdr[off[2:0]];
      end else begin
        sec[k] = view.sec[k];
      end
    end
  end

  assign base_ok = !view.ovf && (view.len >= knxc_pkg::MIN_LEN)
                   && (view.hdr[0] == knxc_pkg::HDR_BYTE0)
                   && (view.hdr[1] == knxc_pkg::HDR_BYTE1)
                   && knxc_pkg::valid_service(view.hdr[2], view.hdr[3]);

  assign tcp_ok = tcp && ((tl + {1'b0, knxc_pkg::MIN_LEN}) <= len)
                  && (sec[0] == knxc_pkg::HDR_BYTE0)
                  && (sec[1] == knxc_pkg::HDR_BYTE1)
                  && knxc_pkg::valid_service(sec[2], sec[3]);

  assign verdict = base_ok && ((tl == len) || tcp_ok);

endmodule

/* hdl/knxnet_ip_packet_classifier_core.sv */
// A byte taken in is held in the input register; when a last byte leaves that register,
// its verdict is registered in the output register.
// Throughput: one byte per cycle; only a held verdict in the output register can stall
// the next last byte. Reset (rst_n low, synchronous) clears the packet state and both
// valid flags.
`include "knxnet_ip_packet_classifier_core_assert.svh"

module knxnet_ip_packet_classifier_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] payload_byte
  input  logic [0:0] in_tuser,   // [0] is_tcp
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] is_knx, [7:1] zero
);

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_tcp_r;
  logic       in_last_r;
  logic       out_v_r;
  logic       out_knx_r;
  logic       fire;
  logic       verdict;

  knxc_pkg::knxc_view_t view;

  // Bytes that give no result move on even while a verdict waits.
  assign fire      = in_v_r && (!in_last_r || !out_v_r || out_tready);
  assign in_tready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_tcp_r  <= in_tuser[0];
      in_last_r <= in_tlast;
    end
  end

  knxc_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (fire),
    .data_byte (in_byte_r),
    .last      (in_last_r),
    .view      (view)
  );

  knxc_classify u_classify (
    .view    (view),
    .tcp     (in_tcp_r),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire && in_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_last_r) begin
      out_knx_r <= verdict;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_knx_r};

  `KNXC_ASSERT_IMP(a_mid_byte_no_stall, in_v_r && !in_last_r, fire)
  `KNXC_ASSERT_NXT(a_last_gives_result, fire && in_last_r, out_tvalid)
  `KNXC_ASSERT_NXT(a_short_rejected, fire && in_last_r && (view.len < knxc_pkg::MIN_LEN),
                   !out_tdata[0])

endmodule

/* tb/knxnet_ip_packet_classifier_core_test.sv */
module knxnet_ip_packet_classifier_core_test;

  typedef logic [7:0] byte_q_t[$];
  typedef enum int {PKT_EXACT, PKT_TCP_TAIL, PKT_SHORT, PKT_NOISE} pkt_kind_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] payload_byte
  logic [0:0] in_tuser = 1'b0;    // [0] is_tcp
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [0] is_knx, [7:1] zero

  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int          errors = 0;

  // Verdicts predicted for packets whose last byte has been accepted, oldest first.
  logic [7:0] verdict_q[$];

  // Predictor copy of the packet state.
  int unsigned pkt_len = 0;
  logic [7:0]  pkt_hdr[6] = '{default: 8'h00};
  logic [7:0]  pkt_tail[4] = '{default: 8'h00};
  logic        pkt_ovf = 1'b0;

  knxnet_ip_packet_classifier_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Code range of a service family; returns 0 for an unknown family.
  function automatic logic service_range(input logic [7:0] fam, output logic [7:0] lo,
                                         output logic [7:0] hi);
    service_range = 1'b1;
    case (fam)
      knxc_pkg::FAM_CORE: begin
        lo = 8'h01; hi = 8'h0C;
      end
      knxc_pkg::FAM_DEVMGMT: begin
        lo = 8'h10; hi = 8'h11;
      end
      knxc_pkg::FAM_TUNNEL: begin
        lo = 8'h20; hi = 8'h25;
      end
      knxc_pkg::FAM_ROUTING: begin
        lo = 8'h30; hi = 8'h33;
      end
      knxc_pkg::FAM_REMLOG: begin
        lo = 8'h40; hi = 8'h43;
      end
      knxc_pkg::FAM_OBJSRV: begin
        lo = 8'h50; hi = 8'h55;
      end
      default: begin
        lo = 8'h00; hi = 8'h00; service_range = 1'b0;
      end
    endcase
  endfunction

  function automatic logic service_ok(input logic [7:0] fam, input logic [7:0] code);
    logic [7:0] lo, hi;
    return service_range(fam, lo, hi) && code >= lo && code <= hi;
  endfunction

  function automatic void pick_service(output logic [7:0] fam, output logic [7:0] code);
    logic [7:0] lo, hi;
    case ($urandom_range(5))
      0: fam = knxc_pkg::FAM_CORE;
      1: fam = knxc_pkg::FAM_DEVMGMT;
      2: fam = knxc_pkg::FAM_TUNNEL;
      3: fam = knxc_pkg::FAM_ROUTING;
      4: fam = knxc_pkg::FAM_REMLOG;
      default: fam = knxc_pkg::FAM_OBJSRV;
    endcase
    void'(service_range(fam, lo, hi));
    code = 8'($urandom_range(hi, lo));
  endfunction

  function automatic logic knx_verdict(input logic tcp);
    int unsigned tl, off;
    logic [7:0]  sec[4];
    if (pkt_ovf || pkt_len < knxc_pkg::MIN_LEN) return 1'b0;
    if (pkt_hdr[0] != knxc_pkg::HDR_BYTE0 || pkt_hdr[1] != knxc_pkg::HDR_BYTE1) return 1'b0;
    if (!service_ok(pkt_hdr[2], pkt_hdr[3])) return 1'b0;
    tl = {pkt_hdr[4], pkt_hdr[5]};
    if (tl == pkt_len) return 1'b1;
    if (!tcp || tl + knxc_pkg::MIN_LEN > pkt_len) return 1'b0;
    // Offsets of the second header that fall inside the first six bytes come from the header.
    for (int k = 0; k < 4; k++) begin
      off = tl + k;
      sec[k] = (off < knxc_pkg::HDR_LEN) ? pkt_hdr[off] : pkt_tail[k];
    end
    return sec[0] == knxc_pkg::HDR_BYTE0 && sec[1] == knxc_pkg::HDR_BYTE1
           && service_ok(sec[2], sec[3]);
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic tcp, input logic last);
    int unsigned tl;
    if (!pkt_ovf) begin
      if (pkt_len < knxc_pkg::HDR_LEN) begin
        pkt_hdr[pkt_len] = b;
      end else begin
        tl = {pkt_hdr[4], pkt_hdr[5]};
        if (pkt_len >= tl && pkt_len < tl + 4) pkt_tail[(pkt_len - tl) & 3] = b;
      end
      if (pkt_len == knxc_pkg::POS_MAX) pkt_ovf = 1'b1;
      else pkt_len++;
    end
    if (last) begin
      verdict_q.push_back({7'd0, knx_verdict(tcp)});
      pkt_len = 0;
      pkt_ovf = 1'b0;
      foreach (pkt_hdr[i]) pkt_hdr[i] = 8'h00;
      foreach (pkt_tail[i]) pkt_tail[i] = 8'h00;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic tcp, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= tcp;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_byte(b, tcp, last);
  endtask

  // The TCP flag only matters on the last byte, so it is random elsewhere.
  task automatic send_packet(input byte_q_t pkt, input logic tcp);
    int unsigned n;
    n = pkt.size();
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n - 1) send_byte(pkt[i], tcp, 1'b1);
      else send_byte(pkt[i], 1'($urandom_range(1)), 1'b0);
    end
  endtask

  function automatic byte_q_t make_packet(input int unsigned len, input logic [15:0] tl,
                                          input logic [7:0] fam, input logic [7:0] code,
                                          input logic with_tail);
    byte_q_t    pkt;
    logic [7:0] b, tfam, tcode;
    for (int unsigned i = 0; i < len; i++) begin
      case (i)
        0: b = knxc_pkg::HDR_BYTE0;
        1: b = knxc_pkg::HDR_BYTE1;
        2: b = fam;
        3: b = code;
        4: b = tl[15:8];
        5: b = tl[7:0];
        default: b = 8'($urandom);
      endcase
      pkt.push_back(b);
    end
    if (with_tail && tl >= knxc_pkg::HDR_LEN && tl + 3 < len) begin
      pick_service(tfam, tcode);
      pkt[tl] = knxc_pkg::HDR_BYTE0;
      pkt[tl + 1] = knxc_pkg::HDR_BYTE1;
      pkt[tl + 2] = tfam;
      pkt[tl + 3] = tcode;
    end
    return pkt;
  endfunction

  task automatic wait_for_verdicts();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: verdict with none pending: expected none, actual %h", $time, out_tdata);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (out_tdata !== want) begin
          $display("%0t: verdict mismatch: expected %h, actual %h", $time, want, out_tdata);
          errors++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  task automatic test_directed_cases();
    logic [7:0] fams[6] = '{knxc_pkg::FAM_CORE, knxc_pkg::FAM_DEVMGMT, knxc_pkg::FAM_TUNNEL,
                            knxc_pkg::FAM_ROUTING, knxc_pkg::FAM_REMLOG,
                            knxc_pkg::FAM_OBJSRV};
    logic [7:0] lo, hi;
    byte_q_t    p;
    in_idle_pct = 0;
    out_stall_pct = 0;
    // Short packets: one byte, and five bytes of a good header.
    send_packet(make_packet(1, 16'd1, knxc_pkg::FAM_CORE, 8'h01, 1'b0), 1'b0);
    send_packet(make_packet(5, 16'd5, knxc_pkg::FAM_CORE, 8'h01, 1'b0), 1'b1);
    // Minimum length with a matching total length.
    send_packet(make_packet(10, 16'd10, knxc_pkg::FAM_CORE, 8'h01, 1'b0), 1'b0);
    // Both edges of every family's code range.
    foreach (fams[f]) begin
      void'(service_range(fams[f], lo, hi));
      if (f % 2 == 0) begin
        send_packet(make_packet(10 + f, 16'(10 + f), fams[f], lo, 1'b0), 1'b0);
        send_packet(make_packet(12, 16'd12, fams[f], hi + 8'd1, 1'b0), 1'b1);
      end else begin
        send_packet(make_packet(10 + f, 16'(10 + f), fams[f], hi, 1'b0), 1'b1);
        send_packet(make_packet(12, 16'd12, fams[f], lo - 8'd1, 1'b0), 1'b0);
      end
    end
    send_packet(make_packet(12, 16'd12, 8'h06, 8'h01, 1'b0), 1'b0);
    // Broken protocol bytes.
    p = make_packet(12, 16'd12, knxc_pkg::FAM_TUNNEL, 8'h20, 1'b0);
    p[0] = 8'h07;
    send_packet(p, 1'b0);
    p = make_packet(12, 16'd12, knxc_pkg::FAM_TUNNEL, 8'h20, 1'b0);
    p[1] = 8'h11;
    send_packet(p, 1'b0);
    wait_for_verdicts();
    // Second header over TCP: fits exactly, wrong transport, one byte short.
    send_packet(make_packet(24, 16'd14, knxc_pkg::FAM_ROUTING, 8'h30, 1'b1), 1'b1);
    send_packet(make_packet(24, 16'd14, knxc_pkg::FAM_ROUTING, 8'h30, 1'b1), 1'b0);
    send_packet(make_packet(23, 16'd14, knxc_pkg::FAM_ROUTING, 8'h30, 1'b1), 1'b1);
    // Total length inside the first header: the second header is read from it.
    send_packet(make_packet(12, 16'd0, knxc_pkg::FAM_CORE, 8'h0C, 1'b0), 1'b1);
    send_packet(make_packet(12, 16'd2, knxc_pkg::FAM_CORE, 8'h0C, 1'b0), 1'b1);
    send_packet(make_packet(14, 16'd4, knxc_pkg::FAM_CORE, 8'h0C, 1'b1), 1'b1);
    // All-ones and all-zeros payloads.
    p = make_packet(10, 16'd10, knxc_pkg::FAM_CORE, 8'h01, 1'b0);
    foreach (p[i]) p[i] = 8'hFF;
    send_packet(p, 1'b1);
    foreach (p[i]) p[i] = 8'h00;
    send_packet(p, 1'b0);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned sent_bytes, sent_pkts, len, r, pos;
    pkt_kind_t   kind;
    logic [7:0]  fam, code;
    logic        tcp;
    byte_q_t     p;
    sent_bytes = 0;
    sent_pkts = 0;
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    while (sent_bytes < 120 || sent_pkts < 5) begin
      r = $urandom_range(99);
      kind = (r < 40) ? PKT_EXACT : (r < 75) ? PKT_TCP_TAIL : (r < 85) ? PKT_SHORT : PKT_NOISE;
      pick_service(fam, code);
      tcp = 1'($urandom_range(1));
      case (kind)
        PKT_EXACT: begin
          len = $urandom_range(40, 10);
          p = make_packet(len, 16'(len), fam, code, 1'b0);
        end
        PKT_TCP_TAIL: begin
          len = $urandom_range(48, 10);
          p = make_packet(len, 16'($urandom_range(len - 10, 0)), fam, code, 1'b1);
          tcp = ($urandom_range(9) != 0);
        end
        PKT_SHORT: begin
          len = $urandom_range(12, 1);
          p = make_packet(len, 16'(len), fam, code, 1'b0);
        end
        default: begin
          len = $urandom_range(30, 1);
          p = make_packet(len, 16'($urandom_range(31)), 8'($urandom), 8'($urandom), 1'b1);
          if ($urandom_range(1) != 0) p[0] = 8'($urandom);
        end
      endcase
      // Occasionally a bit in the first ten bytes takes the inverse of a random bit of its byte.
      if ($urandom_range(99) < 15) begin
        pos = $urandom_range(((len < 10) ? len : 10) - 1, 0);
        p[pos][$urandom_range(7)] = ~p[pos][$urandom_range(7)];
      end
      send_packet(p, tcp);
      sent_bytes += len;
      sent_pkts++;
      if ($urandom_range(99) < 4) wait_for_verdicts();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic(0, 0);
    test_random_traffic(49, 0);
    test_random_traffic(0, 49);
    test_random_traffic(25, 25);
    wait_for_verdicts();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #15_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
